/* rtl/core/sexp_token_lexer_top_defines.svh */
// Assertion macros for the S-expression lexer
`ifndef SEXP_TOKEN_LEXER_TOP_DEFINES_SVH
`define SEXP_TOKEN_LEXER_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SXL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sexp lexer check failed");

// next-cycle implication, checked out of reset
`define SXL_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sexp lexer check failed");

`endif

/* rtl/core/sxl_pkg.sv */
// Types, character codes and helpers shared by the S-expression lexer
`default_nettype none
package sxl_pkg;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_UP_E   = 8'h45;

  localparam logic KIND_EOF   = 1'b0;
  localparam logic KIND_TOKEN = 1'b1;

  localparam logic [13:0] EXP_ACC_MAX = 14'd16383;
  localparam logic [7:0]  COUNT_MAX   = 8'd255;

  typedef enum logic [2:0] {
    MODE_BETWEEN = 3'b001,
    MODE_TOKEN   = 3'b010,
    MODE_COMMENT = 3'b100
  } lex_mode_t;

  typedef enum logic [7:0] {
    PH_START     = 8'b0000_0001,
    PH_SIGNED    = 8'b0000_0010,
    PH_INT       = 8'b0000_0100,
    PH_DOT       = 8'b0000_1000,
    PH_FRAC      = 8'b0001_0000,
    PH_EXP       = 8'b0010_0000,
    PH_EXPSIGNED = 8'b0100_0000,
    PH_EXPDIG    = 8'b1000_0000
  } phase_t;

  typedef enum logic [1:0] {
    TAIL_NONE  = 2'd0,
    TAIL_EOF   = 2'd1,
    TAIL_PAREN = 2'd2
  } tail_t;

  typedef struct packed {
    phase_t      phase;
    logic        still_valid;
    logic        sign_neg;
    logic [63:0] mant;
    logic [7:0]  frac;
    logic [7:0]  dropped;
    logic [13:0] exp_acc;
    logic        exp_neg;
    logic        lost;
  } num_state_t;

  typedef struct packed {
    logic        is_number;
    logic        single;
    logic [7:0]  first_byte;
    logic        negative;
    logic [63:0] mant;
    logic [13:0] exp_acc;
    logic        exp_neg;
    logic [7:0]  frac;
    logic [7:0]  dropped;
    logic        lost;
  } tok_rec_t;

  typedef struct packed {
    logic       has_tok;
    tok_rec_t   tok;
    tail_t      tail;
    logic [7:0] paren_char;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } push_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

  typedef struct packed {
    logic        kind;
    logic        is_number;
    logic        single_valid;
    logic [7:0]  single_char;
    logic        negative;
    logic [63:0] mantissa;
    logic [14:0] dec_exponent;
    logic        precision_lost;
    logic        last;
  } out_word_t;

  function automatic logic [63:0] pow10(input int unsigned n);
    logic [63:0] p;
    p = 64'd1;
    for (int unsigned i = 0; i < n; i++) begin
      p = p * 64'd10;
    end
    return p;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/sxl_front.sv */
// Lexer front end: byte classification, token state and number scan
`default_nettype none
module sxl_front #(
  parameter int TOKEN_BYTES         = 128,
  parameter int MAX_MANTISSA_DIGITS = 19
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic [7:0]    in_byte,
  input  wire logic          in_eoi,
  input  wire logic          room,
  output logic               in_ready,
  output sxl_pkg::push_t     push,
  output logic               lex_idle
);
  import sxl_pkg::*;

  localparam logic [7:0]  LEN_MAX    = 8'(TOKEN_BYTES - 1);
  localparam logic [63:0] MANT_LIMIT = pow10(MAX_MANTISSA_DIGITS - 1);
  localparam num_state_t NUM_CLEAR = '{
    phase: PH_START, still_valid: 1'b1, sign_neg: 1'b0, mant: 64'd0,
    frac: 8'd0, dropped: 8'd0, exp_acc: 14'd0, exp_neg: 1'b0, lost: 1'b0
  };

  lex_mode_t  mode, mode_next;
  num_state_t ns, ns_next;
  logic [7:0] tok_len, tok_len_next;
  logic [7:0] first_byte, first_byte_next;

  num_state_t fin, fout;
  tok_rec_t   cur_rec;
  logic       accept;
  logic       blank, paren, is_hash, is_eol;
  logic       dig, is_e, is_sign;
  logic [3:0] digit;
  logic       add_m, add_m_frac, add_e;
  logic [63:0] mant_step;
  logic [17:0] exp_step;

  always_comb begin
    blank   = (in_byte == CH_SPACE) || (in_byte == CH_CR) ||
              (in_byte == CH_LF) || (in_byte == CH_TAB);
    is_eol  = (in_byte == CH_CR) || (in_byte == CH_LF);
    paren   = (in_byte == CH_LPAREN) || (in_byte == CH_RPAREN);
    is_hash = (in_byte == CH_HASH);
    dig     = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    digit   = in_byte[3:0];
    is_e    = (in_byte == CH_LOW_E) || (in_byte == CH_UP_E);
    is_sign = (in_byte == CH_PLUS) || (in_byte == CH_MINUS);
  end

  // number scan: one step per stored byte
  always_comb begin
    fin        = (mode == MODE_TOKEN) ? ns : NUM_CLEAR;
    fout       = fin;
    add_m      = 1'b0;
    add_m_frac = 1'b0;
    add_e      = 1'b0;
    mant_step  = (fin.mant << 3) + (fin.mant << 1) + {60'd0, digit};
    exp_step   = ({4'd0, fin.exp_acc} << 3) + ({4'd0, fin.exp_acc} << 1) +
                 {14'd0, digit};
    if (fin.still_valid) begin
      case (fin.phase)
        PH_START, PH_SIGNED: begin
          if ((fin.phase == PH_START) && is_sign) begin
            fout.sign_neg = (in_byte == CH_MINUS);
            fout.phase    = PH_SIGNED;
          end else if (dig) begin
            add_m      = 1'b1;
            fout.phase = PH_INT;
          end else if (in_byte == CH_DOT) begin
            fout.phase = PH_DOT;
          end else if (is_e) begin
            fout.phase = PH_EXP;
          end else begin
            fout.still_valid = 1'b0;
          end
        end
        PH_INT: begin
          if (dig) add_m = 1'b1;
          else if (in_byte == CH_DOT) fout.phase = PH_FRAC;
          else if (is_e) fout.phase = PH_EXP;
          else fout.still_valid = 1'b0;
        end
        PH_DOT: begin
          if (dig) begin
            add_m      = 1'b1;
            add_m_frac = 1'b1;
            fout.phase = PH_FRAC;
          end else begin
            fout.still_valid = 1'b0;
          end
        end
        PH_FRAC: begin
          if (dig) begin
            add_m      = 1'b1;
            add_m_frac = 1'b1;
          end else if (is_e) begin
            fout.phase = PH_EXP;
          end else begin
            fout.still_valid = 1'b0;
          end
        end
        PH_EXP: begin
          if (is_sign) begin
            fout.exp_neg = (in_byte == CH_MINUS);
            fout.phase   = PH_EXPSIGNED;
          end else if (dig) begin
            add_e      = 1'b1;
            fout.phase = PH_EXPDIG;
          end else begin
            fout.still_valid = 1'b0;
          end
        end
        PH_EXPSIGNED, PH_EXPDIG: begin
          if (dig) begin
            add_e      = 1'b1;
            fout.phase = PH_EXPDIG;
          end else begin
            fout.still_valid = 1'b0;
          end
        end
        default: fout.still_valid = 1'b0;
      endcase
    end
    if (add_m) begin
      if (fin.mant < MANT_LIMIT) begin
        fout.mant = mant_step;
        if (add_m_frac && (fin.frac != COUNT_MAX)) fout.frac = fin.frac + 8'd1;
      end else begin
        if (!add_m_frac && (fin.dropped != COUNT_MAX)) begin
          fout.dropped = fin.dropped + 8'd1;
        end
        if (digit != 4'd0) fout.lost = 1'b1;
      end
    end
    if (add_e) begin
      if (exp_step > {4'd0, EXP_ACC_MAX}) begin
        fout.exp_acc = EXP_ACC_MAX;
        fout.lost    = 1'b1;
      end else begin
        fout.exp_acc = exp_step[13:0];
      end
    end
  end

  always_comb begin
    cur_rec.is_number  = ns.still_valid && (ns.phase inside
                         {PH_SIGNED, PH_INT, PH_FRAC, PH_EXPDIG});
    cur_rec.single     = (tok_len == 8'd1);
    cur_rec.first_byte = first_byte;
    cur_rec.negative   = ns.sign_neg;
    cur_rec.mant       = ns.mant;
    cur_rec.exp_acc    = ns.exp_acc;
    cur_rec.exp_neg    = ns.exp_neg;
    cur_rec.frac       = ns.frac;
    cur_rec.dropped    = ns.dropped;
    cur_rec.lost       = ns.lost;
  end

  assign in_ready = room;
  assign accept   = in_valid && room;
  assign lex_idle = (mode == MODE_BETWEEN);

  always_comb begin
    mode_next        = mode;
    ns_next          = ns;
    tok_len_next     = tok_len;
    first_byte_next  = first_byte;
    push.push        = 1'b0;
    push.entry.has_tok    = 1'b0;
    push.entry.tok        = cur_rec;
    push.entry.tail       = TAIL_NONE;
    push.entry.paren_char = in_byte;
    if (accept) begin
      if (in_eoi) begin
        push.push          = 1'b1;
        push.entry.has_tok = (mode == MODE_TOKEN);
        push.entry.tail    = TAIL_EOF;
        mode_next          = MODE_BETWEEN;
        ns_next            = NUM_CLEAR;
        tok_len_next       = 8'd0;
        first_byte_next    = 8'd0;
      end else begin
        case (mode)
          MODE_COMMENT: begin
            if (is_eol) mode_next = MODE_BETWEEN;
          end
          MODE_TOKEN: begin
            if (blank || paren || is_hash) begin
              push.push          = 1'b1;
              push.entry.has_tok = 1'b1;
              push.entry.tail    = paren ? TAIL_PAREN : TAIL_NONE;
              mode_next          = is_hash ? MODE_COMMENT : MODE_BETWEEN;
              ns_next            = NUM_CLEAR;
              tok_len_next       = 8'd0;
              first_byte_next    = 8'd0;
            end else if (tok_len < LEN_MAX) begin
              tok_len_next = tok_len + 8'd1;
              ns_next      = fout;
            end
          end
          default: begin
            if (blank) begin
              mode_next = MODE_BETWEEN;
            end else if (is_hash) begin
              mode_next = MODE_COMMENT;
            end else if (paren) begin
              push.push       = 1'b1;
              push.entry.tail = TAIL_PAREN;
              mode_next       = MODE_BETWEEN;
            end else begin
              ns_next         = fout;
              tok_len_next    = 8'd1;
              first_byte_next = in_byte;
              mode_next       = MODE_TOKEN;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_BETWEEN;
      ns         <= NUM_CLEAR;
      tok_len    <= 8'd0;
      first_byte <= 8'd0;
    end else begin
      mode       <= mode_next;
      ns         <= ns_next;
      tok_len    <= tok_len_next;
      first_byte <= first_byte_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/sxl_queue.sv */
// Short queue of per-byte result records between lexer front and back
`default_nettype none
module sxl_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire sxl_pkg::push_t push,
  input  wire logic           pop,
  output logic                room,
  output sxl_pkg::head_t      head
);
  import sxl_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  entry_t        slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign room       = (count != CNT_FULL);
  assign head.valid = (count != '0);
  assign head.entry = slots[rd_ptr];
  assign do_push    = push.push && room;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PW'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PW'(1);
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/sxl_back.sv */
// Lexer back end: expands queue records into result words, output register
`default_nettype none
module sxl_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire sxl_pkg::head_t head,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output sxl_pkg::out_word_t  out_word
);
  import sxl_pkg::*;

  localparam logic signed [16:0] EXP_MAX = 17'sd16383;
  localparam logic signed [16:0] EXP_MIN = -17'sd16384;

  logic      tok_done;
  logic      load, first_pending;
  out_word_t tok_word, tail_word;
  logic signed [16:0] e_base, e_sum;
  logic [14:0] e_sat;
  logic        e_clip;
  tok_rec_t    t;

  always_comb begin
    t      = head.entry.tok;
    e_base = t.exp_neg ? -signed'({3'b000, t.exp_acc}) : signed'({3'b000, t.exp_acc});
    e_sum  = e_base + signed'({9'd0, t.dropped}) - signed'({9'd0, t.frac});
    e_clip = 1'b0;
    e_sat  = e_sum[14:0];
    if (e_sum > EXP_MAX) begin
      e_sat  = EXP_MAX[14:0];
      e_clip = 1'b1;
    end else if (e_sum < EXP_MIN) begin
      e_sat  = EXP_MIN[14:0];
      e_clip = 1'b1;
    end
    tok_word.kind           = KIND_TOKEN;
    tok_word.is_number      = t.is_number;
    tok_word.single_valid   = t.single;
    tok_word.single_char    = t.single ? t.first_byte : 8'd0;
    tok_word.negative       = t.is_number && t.negative;
    tok_word.mantissa       = t.is_number ? t.mant : 64'd0;
    tok_word.dec_exponent   = t.is_number ? e_sat : 15'd0;
    tok_word.precision_lost = t.is_number && (t.lost || e_clip);
    tok_word.last           = (head.entry.tail == TAIL_NONE);

    tail_word      = '0;
    tail_word.last = 1'b1;
    if (head.entry.tail == TAIL_PAREN) begin
      tail_word.kind         = KIND_TOKEN;
      tail_word.single_valid = 1'b1;
      tail_word.single_char  = head.entry.paren_char;
    end else begin
      tail_word.kind = KIND_EOF;
    end
  end

  assign first_pending = head.entry.has_tok && !tok_done;
  assign load = head.valid && (!out_valid || out_ready);
  assign pop  = load && (!first_pending || (head.entry.tail == TAIL_NONE));

  always_ff @(posedge clk) begin
    if (load) begin
      out_word <= first_pending ? tok_word : tail_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      tok_done  <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        tok_done  <= !pop;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/sexp_token_lexer_top.sv */
// S-expression lexer top level: front end, record queue, back end.
// A byte's result words pass through the record queue and then the output register.
// Throughput: one byte per cycle while the queue has room; a byte that yields two
// words holds the back end, absorbed by the QUEUE_DEPTH-entry record queue.
// Reset (synchronous): lexer returns to between tokens, queue and output empty.
`default_nettype none
`include "sexp_token_lexer_top_defines.svh"
module sexp_token_lexer_top #(
  parameter int TOKEN_BYTES         = 128,
  parameter int MAX_MANTISSA_DIGITS = 19,
  parameter int QUEUE_DEPTH         = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // byte_in
  input  wire logic        s_axis_tuser,   // end_of_input
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // is_number, single_valid, single_char[8], negative, mantissa[64],
  // dec_exponent[15], precision_lost, zero pad[5]
  output logic [95:0]      m_axis_tdata,
  output logic             m_axis_tuser,   // kind
  output logic             m_axis_tlast
);
  import sxl_pkg::*;

  push_t     push;
  head_t     head;
  logic      room, pop, lex_idle;
  out_word_t word;

  sxl_front #(
    .TOKEN_BYTES         (TOKEN_BYTES),
    .MAX_MANTISSA_DIGITS (MAX_MANTISSA_DIGITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_byte  (s_axis_tdata),
    .in_eoi   (s_axis_tuser),
    .room     (room),
    .in_ready (s_axis_tready),
    .push     (push),
    .lex_idle (lex_idle)
  );

  sxl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .room (room),
    .head (head)
  );

  sxl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_word  (word)
  );

  assign m_axis_tdata = {5'd0, word.precision_lost, word.dec_exponent, word.mantissa,
                         word.negative, word.single_char, word.single_valid,
                         word.is_number};
  assign m_axis_tuser = word.kind;
  assign m_axis_tlast = word.last;

  `SXL_ASSERT_IMP(a_eof_is_last, clk, rst, m_axis_tvalid && (m_axis_tuser == KIND_EOF), m_axis_tlast)
  `SXL_ASSERT_NXT(a_eoi_resets, clk, rst, s_axis_tvalid && s_axis_tready && s_axis_tuser, lex_idle)
  `SXL_ASSERT_IMP(a_non_number_zero, clk, rst, m_axis_tvalid && !m_axis_tdata[0], (m_axis_tdata[90:10] == 81'd0))

endmodule
`default_nettype wire
